// ===== src/stpi_pkg.sv =====
// ----------------------------------------------------------------------------
// stpi_pkg: shared types and constants of the sparse product issuer
// Holds the pairing modes, the register indexes and the job record that
// travels from the front part to the back part through the job queue.
// ----------------------------------------------------------------------------
package stpi_pkg;

	localparam int ADDR_WIDTH_DEF    = 16;
	localparam int A_INDEX_WIDTH_DEF = 4;
	localparam int B_INDEX_WIDTH_DEF = 4;
	localparam int MAX_DIM_DEF       = 16;
	localparam int MAX_BLOCK_DEF     = 4;
	localparam int RUN_CAP           = 64;
	localparam int IDX_W             = 5;
	localparam int CFG_IDX_W         = 2;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

	typedef enum logic [3:0] {
		MODE_DD   = 4'b0001,
		MODE_DB   = 4'b0010,
		MODE_BD   = 4'b0100,
		MODE_BB   = 4'b1000
	} mode_t;

	// Job record. Loop nest after classification: outer i, middle k, inner j,
	// except for a diagonal A against a block B, where k is the inner loop.
	// Inner index j runs lo..hi-1; row = row0 + i, col = col0 + k, with a j term in place of i or k on a diagonal side.
	typedef struct packed {
		logic        done;
		mode_t       mode;
		logic [15:0] a_base;
		logic [15:0] b_base;
		logic [6:0]  lo;
		logic [6:0]  hi;
		logic [6:0]  ni;     // outer count
		logic [6:0]  nk;     // middle count
		logic [4:0]  asi;
		logic [4:0]  asj;
		logic [4:0]  bsj;
		logic [4:0]  bsk;
		logic [3:0]  ajw;
		logic [3:0]  bkw;
	} job_t;

	typedef struct packed {
		logic [3:0]  dest_row;
		logic [3:0]  dest_col;
		logic [31:0] a_word;
		logic [31:0] b_word;
		logic [1:0]  a_lane;
		logic [1:0]  b_lane;
		logic        end_marker;
		logic        run_last;
	} prod_t;

endpackage

// ===== src/stpi_if.sv =====
// ----------------------------------------------------------------------------
// stpi_if: valid/ready channel interfaces
// Descriptor, result and configuration channels of the issuer.
// ----------------------------------------------------------------------------
interface stpi_desc_if;
	logic        valid;
	logic        ready;
	logic [15:0] a_base_addr;
	logic [4:0]  a_row_start;
	logic [4:0]  a_col_start;
	logic [4:0]  a_row_end;
	logic [4:0]  a_col_end;
	logic [15:0] b_base_addr;
	logic [4:0]  b_row_start;
	logic [4:0]  b_col_start;
	logic [4:0]  b_row_end;
	logic [4:0]  b_col_end;
	logic        job_done;
	modport source (output valid, a_base_addr, a_row_start, a_col_start, a_row_end,
		a_col_end, b_base_addr, b_row_start, b_col_start, b_row_end, b_col_end,
		job_done, input ready);
	modport sink (input valid, a_base_addr, a_row_start, a_col_start, a_row_end,
		a_col_end, b_base_addr, b_row_start, b_col_start, b_row_end, b_col_end,
		job_done, output ready);
endinterface

interface stpi_res_if #(parameter int AW = 16);
	logic          valid;
	logic          ready;
	logic [3:0]    dest_row;
	logic [3:0]    dest_col;
	logic [AW-1:0] a_word_addr;
	logic [AW-1:0] b_word_addr;
	logic [1:0]    a_lane;
	logic [1:0]    b_lane;
	logic          a_hit;
	logic          b_hit;
	logic          end_marker;
	logic          run_last;
	modport source (output valid, dest_row, dest_col, a_word_addr, b_word_addr,
		a_lane, b_lane, a_hit, b_hit, end_marker, run_last, input ready);
	modport sink (input valid, dest_row, dest_col, a_word_addr, b_word_addr,
		a_lane, b_lane, a_hit, b_hit, end_marker, run_last, output ready);
endinterface

interface stpi_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [4:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/stpi_front.sv =====
// ----------------------------------------------------------------------------
// stpi_front: descriptor classifier
// Picks the pairing mode, clamps extents and works out the inner range and
// loop counts of one descriptor; the result is registered as a job record.
// ----------------------------------------------------------------------------
module stpi_front #(
	parameter int MAX_BLOCK = stpi_pkg::MAX_BLOCK_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	stpi_desc_if.sink         desc,
	input  logic [4:0]        a_rows,
	input  logic [4:0]        a_cols,
	input  logic [4:0]        b_rows,
	input  logic [4:0]        b_cols,
	output logic              job_valid,
	input  logic              job_ready,
	output stpi_pkg::job_t    job
);

	localparam logic [4:0] MAXB = 5'(MAX_BLOCK);

	stpi_pkg::job_t job_d;
	stpi_pkg::job_t job_q;
	logic           valid_q;

	function automatic logic [4:0] ssub(input logic [4:0] x, input logic [4:0] y);
		return (x > y) ? x - y : 5'd0;
	endfunction
	function automatic logic [6:0] mn(input logic [6:0] x, input logic [6:0] y);
		return (x < y) ? x : y;
	endfunction

	logic [4:0] asi, asj, aei, aej, bsj, bsk, bej, bek;
	logic [4:0] aiw, ajw, bjw, bkw, ac, bc;
	logic [6:0] aend, bend, a_lim, b_lim;

	always_comb begin
		asi = desc.a_row_start; asj = desc.a_col_start;
		aei = desc.a_row_end;   aej = desc.a_col_end;
		bsj = desc.b_row_start; bsk = desc.b_col_start;
		bej = desc.b_row_end;   bek = desc.b_col_end;
		aiw = (ssub(aei, asi) < MAXB) ? ssub(aei, asi) : MAXB;
		ajw = (ssub(aej, asj) < MAXB) ? ssub(aej, asj) : MAXB;
		bjw = (ssub(bej, bsj) < MAXB) ? ssub(bej, bsj) : MAXB;
		bkw = (ssub(bek, bsk) < MAXB) ? ssub(bek, bsk) : MAXB;
		aend = mn(7'(ssub(a_rows, asi)), 7'(ssub(a_cols, asj)));
		bend = mn(7'(ssub(b_rows, bsj)), 7'(ssub(b_cols, bsk)));
		ac = (asj < bsj) ? bsj - asj : 5'd0;
		bc = (asj > bsj) ? asj - bsj : 5'd0;
		a_lim = mn(7'(a_cols), 7'(asj) + 7'(ssub(a_rows, asi)));
		b_lim = mn(7'(b_rows), 7'(bsj) + 7'(ssub(b_cols, bsk)));
		job_d        = '0;
		job_d.done   = desc.job_done;
		job_d.a_base = desc.a_base_addr;
		job_d.b_base = desc.b_base_addr;
		job_d.asi    = asi;
		job_d.asj    = asj;
		job_d.bsj    = bsj;
		job_d.bsk    = bsk;
		job_d.ajw    = 4'(ajw);
		job_d.bkw    = 4'(bkw);
		job_d.lo     = (asj > bsj) ? 7'(asj) : 7'(bsj);
		job_d.ni     = 7'd1;
		job_d.nk     = 7'd1;
		if (aei == '0 && bej == '0) begin
			// Diagonal pair: j counts along the A diagonal from ac.
			job_d.mode = stpi_pkg::MODE_DD;
			job_d.lo   = 7'(ac);
			job_d.hi   = mn(aend, 7'(ac) + bend - ((7'(bc) < bend) ? 7'(bc) : bend));
			if (7'(bc) >= bend) job_d.hi = 7'(ac);
		end else if (aei == '0) begin
			job_d.mode = stpi_pkg::MODE_DB;
			job_d.hi   = mn(a_lim, 7'(bsj) + 7'(bjw));
			job_d.nk   = 7'(bkw);
		end else if (bej == '0) begin
			job_d.mode = stpi_pkg::MODE_BD;
			job_d.hi   = mn(7'(asj) + 7'(ajw), b_lim);
			job_d.ni   = 7'(aiw);
		end else begin
			job_d.mode = stpi_pkg::MODE_BB;
			job_d.hi   = mn(7'(asj) + 7'(ajw), 7'(bsj) + 7'(bjw));
			job_d.ni   = 7'(aiw);
			job_d.nk   = 7'(bkw);
		end
	end

	assign desc.ready = !valid_q || job_ready;
	assign job_valid  = valid_q;
	assign job        = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (desc.ready) begin
			valid_q <= desc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (desc.ready && desc.valid) begin
			job_q <= job_d;
		end
	end

endmodule

// ===== src/stpi_queue.sv =====
// ----------------------------------------------------------------------------
// stpi_queue: job queue
// Short FIFO of job records between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module stpi_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stpi_pkg::job_t in_job,
	output logic           out_valid,
	input  logic           out_ready,
	output stpi_pkg::job_t out_job
);

	stpi_pkg::job_t entry_q [stpi_pkg::QUEUE_DEPTH];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;

	assign in_ready  = cnt_q != 2'(stpi_pkg::QUEUE_DEPTH);
	assign out_valid = cnt_q != 2'd0;
	assign out_job   = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= !wr_q;
			if (out_valid && out_ready) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) entry_q[wr_q] <= in_job;
	end

endmodule

// ===== src/stpi_back.sv =====
// ----------------------------------------------------------------------------
// stpi_back: product sequencer and tag filter
// Steps the i/k/j loop nest of one job, one product per cycle unless stalled, forms
// word addresses and lanes in stage 1 and looks up the tag filters in stage 2.
// ----------------------------------------------------------------------------
module stpi_back #(
	parameter int ADDR_WIDTH    = stpi_pkg::ADDR_WIDTH_DEF,
	parameter int A_INDEX_WIDTH = stpi_pkg::A_INDEX_WIDTH_DEF,
	parameter int B_INDEX_WIDTH = stpi_pkg::B_INDEX_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  stpi_pkg::job_t job,
	stpi_res_if.source     res
);

	localparam int AD = 1 << A_INDEX_WIDTH;
	localparam int BD = 1 << B_INDEX_WIDTH;
	localparam int AT = ADDR_WIDTH - A_INDEX_WIDTH;
	localparam int BT = ADDR_WIDTH - B_INDEX_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t         state_q;
	stpi_pkg::job_t cur_q;
	logic [6:0]     i_q, k_q, j_q, cnt_q;

	// Stage 1 and stage 2 product registers.
	logic                  v_s1;
	stpi_pkg::prod_t       p_s1;
	logic                  v_s2;
	stpi_pkg::prod_t       p_s2;
	logic                  ah_s2, bh_s2;

	logic [AD-1:0]         a_vld_q;
	logic [AT-1:0]         a_tag_q [AD];
	logic [BD-1:0]         b_vld_q;
	logic [BT-1:0]         b_tag_q [BD];

	logic       adv, s1_free, empty, last;
	logic [6:0] aoff, boff, row, col, jn, kn, in_;
	logic [6:0] ajmul, bkmul;
	logic [ADDR_WIDTH-1:0] aw, bw;

	assign adv     = !v_s2 || res.ready;
	assign s1_free = !v_s1 || adv;
	assign empty   = (cur_q.lo >= cur_q.hi) || (cur_q.ni == '0) || (cur_q.nk == '0);
	assign job_ready = (state_q == ST_IDLE) && s1_free;

	always_comb begin
		jn = j_q + 7'd1;
		kn = k_q + 7'd1;
		in_ = i_q + 7'd1;
		ajmul = 7'(i_q[2:0]) * 7'(cur_q.ajw);
		bkmul = 7'((j_q - 7'(cur_q.bsj)) * cur_q.bkw);
		last = (jn >= cur_q.hi) && (kn >= cur_q.nk) && (in_ >= cur_q.ni);
		aoff = '0; boff = '0; row = '0; col = '0;
		unique case (cur_q.mode)
			stpi_pkg::MODE_DD: begin
				aoff = j_q;
				boff = j_q + 7'(cur_q.asj) - 7'(cur_q.bsj);
				row  = 7'(cur_q.asi) + aoff;
				col  = 7'(cur_q.bsk) + boff;
			end
			stpi_pkg::MODE_DB: begin
				aoff = j_q - 7'(cur_q.asj);
				boff = bkmul + k_q;
				row  = 7'(cur_q.asi) + aoff;
				col  = 7'(cur_q.bsk) + k_q;
			end
			stpi_pkg::MODE_BD: begin
				aoff = ajmul + j_q - 7'(cur_q.asj);
				boff = j_q - 7'(cur_q.bsj);
				row  = 7'(cur_q.asi) + i_q;
				col  = 7'(cur_q.bsk) + boff;
			end
			default: begin
				aoff = ajmul + j_q - 7'(cur_q.asj);
				boff = bkmul + k_q;
				row  = 7'(cur_q.asi) + i_q;
				col  = 7'(cur_q.bsk) + k_q;
			end
		endcase
		aw = ADDR_WIDTH'(cur_q.a_base) + ADDR_WIDTH'(aoff[6:2]);
		bw = ADDR_WIDTH'(cur_q.b_base) + ADDR_WIDTH'(boff[6:2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
		end else begin
			if (s1_free) v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && s1_free) begin
						if (job.done) v_s1 <= 1'b1;
						else state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (empty) state_q <= ST_IDLE;
					else if (s1_free) begin
						v_s1 <= 1'b1;
						if (last || cnt_q == 7'(stpi_pkg::RUN_CAP - 1)) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid && s1_free) begin
			cur_q <= job;
			i_q   <= '0;
			k_q   <= '0;
			j_q   <= job.lo;
			cnt_q <= '0;
			p_s1  <= '{end_marker: 1'b1, run_last: 1'b1, default: '0};
		end else if (state_q == ST_RUN && !empty && s1_free) begin
			p_s1.dest_row   <= row[3:0];
			p_s1.dest_col   <= col[3:0];
			p_s1.a_word     <= 32'(aw);
			p_s1.b_word     <= 32'(bw);
			p_s1.a_lane     <= aoff[1:0];
			p_s1.b_lane     <= boff[1:0];
			p_s1.end_marker <= 1'b0;
			p_s1.run_last   <= last || cnt_q == 7'(stpi_pkg::RUN_CAP - 1);
			cnt_q <= cnt_q + 7'd1;
			// A diagonal A against a block B walks k inside j.
			if (cur_q.mode == stpi_pkg::MODE_DB) begin
				if (kn < cur_q.nk) k_q <= kn;
				else begin
					k_q <= '0;
					j_q <= jn;
				end
			end else if (jn < cur_q.hi) j_q <= jn;
			else begin
				j_q <= cur_q.lo;
				if (kn < cur_q.nk) k_q <= kn;
				else begin
					k_q <= '0;
					i_q <= in_;
				end
			end
		end
	end

	// Stage 2: tag filter lookup and install.
	logic [A_INDEX_WIDTH-1:0] ai;
	logic [B_INDEX_WIDTH-1:0] bi;
	logic [AT-1:0]            atg;
	logic [BT-1:0]            btg;
	logic                     ah, bh;

	always_comb begin
		ai  = p_s1.a_word[A_INDEX_WIDTH-1:0];
		bi  = p_s1.b_word[B_INDEX_WIDTH-1:0];
		atg = p_s1.a_word[ADDR_WIDTH-1:A_INDEX_WIDTH];
		btg = p_s1.b_word[ADDR_WIDTH-1:B_INDEX_WIDTH];
		ah  = a_vld_q[ai] && a_tag_q[ai] == atg;
		bh  = b_vld_q[bi] && b_tag_q[bi] == btg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			a_vld_q <= '0;
			b_vld_q <= '0;
		end else if (adv) begin
			v_s2 <= v_s1;
			if (v_s1 && !p_s1.end_marker) begin
				a_vld_q[ai] <= 1'b1;
				b_vld_q[bi] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			p_s2  <= p_s1;
			ah_s2 <= ah && !p_s1.end_marker;
			bh_s2 <= bh && !p_s1.end_marker;
			if (!p_s1.end_marker) begin
				a_tag_q[ai] <= atg;
				b_tag_q[bi] <= btg;
			end
		end
	end

	assign res.valid       = v_s2;
	assign res.dest_row    = p_s2.dest_row;
	assign res.dest_col    = p_s2.dest_col;
	assign res.a_word_addr = p_s2.a_word[ADDR_WIDTH-1:0];
	assign res.b_word_addr = p_s2.b_word[ADDR_WIDTH-1:0];
	assign res.a_lane      = p_s2.a_lane;
	assign res.b_lane      = p_s2.b_lane;
	assign res.a_hit       = ah_s2;
	assign res.b_hit       = bh_s2;
	assign res.end_marker  = p_s2.end_marker;
	assign res.run_last    = p_s2.run_last;

	ap_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state not one-hot");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !res.ready |=> v_s2 && $stable(p_s2))
		else $error("stalled result changed");
	ap_end: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && p_s2.end_marker |-> p_s2.run_last && !ah_s2 && !bh_s2)
		else $error("end marker malformed");

endmodule

// ===== src/sparse_task_product_issuer_top.sv =====
// A descriptor passes the classify register, the queue, the job load, the address
// stage and the tag-filter stage; products then follow one per cycle unless stalled.
// The sequencer issues one product or end marker per cycle unless stalled; it takes
// no new job during a run, and an empty overlap enters the run state with no product.
// Reset clears the registers to 16, the tag filters to all invalid, and the queue.
// ----------------------------------------------------------------------------
// sparse_task_product_issuer_top: sparse tile product issuer
// Expands tile descriptor pairs into single-product multiply instructions.
// ----------------------------------------------------------------------------
module sparse_task_product_issuer_top #(
	parameter int ADDR_WIDTH    = stpi_pkg::ADDR_WIDTH_DEF,
	parameter int A_INDEX_WIDTH = stpi_pkg::A_INDEX_WIDTH_DEF,
	parameter int B_INDEX_WIDTH = stpi_pkg::B_INDEX_WIDTH_DEF,
	parameter int MAX_BLOCK     = stpi_pkg::MAX_BLOCK_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	stpi_desc_if.sink     desc,
	stpi_cfg_if.sink      cfg,
	stpi_res_if.source    res
);

	logic [4:0]     a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic           fj_valid, fj_ready, bj_valid, bj_ready;
	stpi_pkg::job_t fj, bj;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= 5'd16;
			a_cols_q <= 5'd16;
			b_rows_q <= 5'd16;
			b_cols_q <= 5'd16;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				stpi_pkg::REG_A_ROWS: a_rows_q <= cfg.data;
				stpi_pkg::REG_A_COLS: a_cols_q <= cfg.data;
				stpi_pkg::REG_B_ROWS: b_rows_q <= cfg.data;
				stpi_pkg::REG_B_COLS: b_cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	stpi_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk(clk), .arst_n(arst_n), .desc(desc),
		.a_rows(a_rows_q), .a_cols(a_cols_q), .b_rows(b_rows_q), .b_cols(b_cols_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	stpi_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
		.out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
	);

	stpi_back #(
		.ADDR_WIDTH(ADDR_WIDTH), .A_INDEX_WIDTH(A_INDEX_WIDTH),
		.B_INDEX_WIDTH(B_INDEX_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj), .res(res)
	);

endmodule
